>>> sv/casqd_pkg.sv
// Shared types, codes and constants for the class-affinity queue dispatcher.
package casqd_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_QUEUES      = 4;
    localparam int CODE_BITS       = 32;
    localparam int CODE_KEEP       = (CODE_BITS < 32) ? CODE_BITS : 32;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_LKP = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADCLS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CLS_A = 2'd0,
        CLS_B = 2'd1,
        CLS_C = 2'd2,
        CLS_X = 2'd3
    } t_cls;

    typedef enum logic [2:0] {
        K_ENQ,
        K_DEQ,
        K_LKP,
        K_NOP,
        K_BAD
    } t_kind;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] job_code;
        logic [1:0]  job_class;
        logic [15:0] job_quantity;
        logic [1:0]  queue_select;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  queue_index;
        logic        found;
        logic [31:0] out_code;
        logic [1:0]  out_class;
        logic [15:0] out_quantity;
        logic [4:0]  length_q0;
        logic [4:0]  length_q1;
        logic [4:0]  length_q2;
        logic [4:0]  length_q3;
    } t_res;

    typedef struct packed {
        t_kind                kind;
        logic [CODE_KEEP-1:0] code;
        logic [1:0]           cls;
        logic [15:0]          qty;
        logic [1:0]           sel;
    } t_cmd;

endpackage

>>> sv/casqd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module casqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> sv/casqd_front.sv
// Front end: takes requests, decodes them into commands and buffers two.
module casqd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  casqd_pkg::t_req i_req,
    output logic           o_cmd_valid,
    output casqd_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import casqd_pkg::*;

    t_cmd       r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    always_comb begin
        w_cmd.code = i_req.job_code[CODE_KEEP-1:0];
        w_cmd.cls  = i_req.job_class;
        w_cmd.qty  = i_req.job_quantity;
        w_cmd.sel  = i_req.queue_select;
        unique case (t_op'(i_req.operation))
            OP_ENQ:  w_cmd.kind = (t_cls'(i_req.job_class) == CLS_X) ? K_BAD : K_ENQ;
            OP_DEQ:  w_cmd.kind = K_DEQ;
            OP_LKP:  w_cmd.kind = K_LKP;
            OP_NOP:  w_cmd.kind = K_NOP;
            default: w_cmd.kind = K_NOP;
        endcase
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end
endmodule

>>> sv/casqd_back.sv
// Back end: runs commands against the four queues and holds the result register.
module casqd_back #(
    parameter int QUEUE_DEPTH = casqd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  casqd_pkg::t_cmd i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output casqd_pkg::t_res o_res
);
    import casqd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int AW = PW + 2;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = CODE_KEEP + 2 + 16;
    localparam logic [PW:0]   DEPTH_P = (PW+1)'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(QUEUE_DEPTH - 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_RD, S_SCAN} t_state;

    t_state         r_state, n_state;
    logic [PW-1:0]  r_head [NUM_QUEUES], n_head [NUM_QUEUES];
    logic [PW-1:0]  r_tail [NUM_QUEUES], n_tail [NUM_QUEUES];
    logic [LW-1:0]  r_len  [NUM_QUEUES], n_len  [NUM_QUEUES];
    logic           r_out_valid, n_out_valid;
    t_res           r_res, n_res;
    logic [1:0]     r_sel, n_sel;
    logic [CODE_KEEP-1:0] r_code, n_code;
    logic [AW:0]    r_idx, n_idx;
    logic           r_chk_v, n_chk_v;
    logic [AW-1:0]  r_chk_a, n_chk_a;
    logic           r_found, n_found;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic [DW-1:0]  wdata, rdata;
    logic           out_free, emit;
    logic [1:0]     q, lo;
    logic [1:0]     cq;
    logic [PW-1:0]  cp, ch;
    logic [PW:0]    off;
    logic           held;

    casqd_ram #(.WIDTH(DW), .DEPTH(NUM_QUEUES << PW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        return (p == LAST_P) ? '0 : p + PW'(1);
    endfunction

    assign out_free = !r_out_valid || !i_stall;

    // position of the checked entry relative to its queue head
    always_comb begin
        cq   = r_chk_a[AW-1:PW];
        cp   = r_chk_a[PW-1:0];
        ch   = r_head[cq];
        off  = (cp >= ch) ? ({1'b0, cp} - {1'b0, ch}) : ({1'b0, cp} + DEPTH_P - {1'b0, ch});
        held = ({1'b0, cp} < DEPTH_P) && (off < (PW+1)'(r_len[cq]));
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_len       = r_len;
        n_out_valid = r_out_valid && i_stall;
        n_res       = r_res;
        n_sel       = r_sel;
        n_code      = r_code;
        n_idx       = r_idx;
        n_chk_v     = 1'b0;
        n_chk_a     = r_chk_a;
        n_found     = r_found;
        o_pop       = 1'b0;
        we          = 1'b0;
        waddr       = '0;
        wdata       = {i_cmd.code, i_cmd.cls, i_cmd.qty};
        raddr       = r_idx[AW-1:0];
        emit        = 1'b0;
        lo          = (t_cls'(i_cmd.cls) == CLS_A) ? 2'd0 : 2'd1;
        q           = (t_cls'(i_cmd.cls) == CLS_C) ? 2'd2 :
                      ((r_len[lo] <= r_len[3]) ? lo : 2'd3);

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_pop = 1'b1;
                    n_res = '0;
                    unique case (i_cmd.kind)
                        K_ENQ: begin
                            n_res.queue_index = q;
                            emit = 1'b1;
                            if (r_len[q] >= DEPTH_L) begin
                                n_res.status = ST_FULL;
                            end else begin
                                we        = 1'b1;
                                waddr     = {q, r_tail[q]};
                                n_tail[q] = advance(r_tail[q]);
                                n_len[q]  = r_len[q] + LW'(1);
                            end
                        end
                        K_DEQ: begin
                            n_sel = i_cmd.sel;
                            if (r_len[i_cmd.sel] == '0) begin
                                n_res.status      = ST_EMPTY;
                                n_res.queue_index = i_cmd.sel;
                                emit = 1'b1;
                            end else begin
                                raddr   = {i_cmd.sel, r_head[i_cmd.sel]};
                                n_state = S_RD;
                            end
                        end
                        K_LKP: begin
                            n_code  = i_cmd.code;
                            n_idx   = '0;
                            n_found = 1'b0;
                            n_state = S_SCAN;
                        end
                        K_BAD: begin
                            n_res.status = ST_BADCLS;
                            emit = 1'b1;
                        end
                        K_NOP: emit = 1'b1;
                        default: emit = 1'b1;
                    endcase
                end
            end
            S_RD: begin
                n_res.status       = ST_OK;
                n_res.queue_index  = r_sel;
                n_res.out_code     = 32'(rdata[DW-1 -: CODE_KEEP]);
                n_res.out_class    = rdata[17:16];
                n_res.out_quantity = rdata[15:0];
                n_head[r_sel]      = advance(r_head[r_sel]);
                n_len[r_sel]       = r_len[r_sel] - LW'(1);
                emit    = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                // issue one address a cycle, compare it the cycle after
                if (!r_idx[AW]) begin
                    n_chk_v = 1'b1;
                    n_chk_a = r_idx[AW-1:0];
                    n_idx   = r_idx + (AW+1)'(1);
                end
                if (r_chk_v && held && (rdata[DW-1 -: CODE_KEEP] == r_code)) begin
                    n_found = 1'b1;
                end
                if (r_idx[AW] && !r_chk_v) begin
                    n_res.found = r_found;
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (emit) begin
            n_out_valid     = 1'b1;
            n_res.length_q0 = 5'(n_len[0]);
            n_res.length_q1 = 5'(n_len[1]);
            n_res.length_q2 = 5'(n_len[2]);
            n_res.length_q3 = 5'(n_len[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_sel   <= n_sel;
        r_code  <= n_code;
        r_chk_a <= n_chk_a;
        r_found <= n_found;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_chk_v     <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_len[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_chk_v     <= n_chk_v;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_len       <= n_len;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;
endmodule

>>> sv/class_affinity_shortest_queue_dispatch.sv
// Four-queue job dispatcher: enqueue A/B to the shorter of queue 0/1 and 3, C to queue 2;
// dequeue; code lookup. Enqueue and rejected results: one per cycle unless i_stall holds.
// Dequeue: the job store's registered read port adds state S_RD before the result.
// Lookup: one store entry is compared per cycle.
// Up to two requests are buffered ahead of the execution unit.
// Synchronous reset empties all queues; the job store itself is not cleared.
module class_affinity_shortest_queue_dispatch #(
    parameter int QUEUE_DEPTH = casqd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  casqd_pkg::t_req i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output casqd_pkg::t_res o_res
);
    import casqd_pkg::*;

    logic cmd_valid, pop;
    t_cmd cmd;

    casqd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_pop      (pop)
    );

    casqd_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> cmd_valid) else $error("command popped from empty buffer");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status == ST_EMPTY) |->
            (o_res.queue_index == 2'd0 && o_res.length_q0 == 5'd0) ||
            (o_res.queue_index == 2'd1 && o_res.length_q1 == 5'd0) ||
            (o_res.queue_index == 2'd2 && o_res.length_q2 == 5'd0) ||
            (o_res.queue_index == 2'd3 && o_res.length_q3 == 5'd0))
        else $error("empty status on nonempty queue");

    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status == ST_BADCLS) |->
            (o_res.queue_index == 2'd0 && !o_res.found))
        else $error("dropped request carries queue or lookup data");
endmodule
